### design/fdp_pkg.sv
// ----------------------------------------------------------------------------
// fdp_pkg
// Types, register indexes and key/lane helpers for the float delta prefilter.
// ----------------------------------------------------------------------------
package fdp_pkg;

  localparam int WORD_W   = 32;
  localparam int LANE_W   = 8;
  localparam int LANES    = WORD_W / LANE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_WISE = 2'd1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } item_t;

  typedef struct packed {
    logic direction;
    logic byte_wise;
  } mode_t;

  function automatic logic [WORD_W-1:0] to_key(input logic [WORD_W-1:0] bits);
    return bits[WORD_W-1] ? ~bits : (bits ^ SIGN_BIT);
  endfunction

  function automatic logic [WORD_W-1:0] from_key(input logic [WORD_W-1:0] key);
    return key[WORD_W-1] ? (key ^ SIGN_BIT) : ~key;
  endfunction

  function automatic logic [WORD_W-1:0] lanes_sub(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < LANES; i++) begin
      r[i*LANE_W +: LANE_W] = a[i*LANE_W +: LANE_W] - b[i*LANE_W +: LANE_W];
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] lanes_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < LANES; i++) begin
      r[i*LANE_W +: LANE_W] = a[i*LANE_W +: LANE_W] + b[i*LANE_W +: LANE_W];
    end
    return r;
  endfunction

endpackage

### design/fdp_stream_if.sv
// ----------------------------------------------------------------------------
// fdp_in_if / fdp_out_if
// Valid/ready stream channels for input words and result words.
// ----------------------------------------------------------------------------
interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        last_in;

  modport source (output valid, output data_word, output last_in, input ready);
  modport sink   (input valid, input data_word, input last_in, output ready);
endinterface

interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_out;

  modport source (output valid, output out_word, output last_out, input ready);
  modport sink   (input valid, input out_word, input last_out, output ready);
endinterface

### design/fdp_front.sv
// ----------------------------------------------------------------------------
// fdp_front
// Accepts input words; in forward mode maps float bits to the ordered key.
// ----------------------------------------------------------------------------
module fdp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  fdp_pkg::mode_t mode,
  fdp_in_if.sink        in_s,
  output logic          q_valid,
  input  logic          q_ready,
  output fdp_pkg::item_t q_item
);
  import fdp_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_s.ready = !valid_r || q_ready;
  assign take       = in_s.valid && in_s.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt     = 1'b1;
      item_nxt.word = mode.direction ? in_s.data_word : to_key(in_s.data_word);
      item_nxt.last = in_s.last_in;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

### design/fdp_queue.sv
// ----------------------------------------------------------------------------
// fdp_queue
// Two-entry word queue between front and back.
// ----------------------------------------------------------------------------
module fdp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  fdp_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output fdp_pkg::item_t rd_item
);
  import fdp_pkg::*;

  logic [1:0] count_r, count_nxt;
  item_t      head_r, head_nxt;
  item_t      tail_r, tail_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = head_r;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_nxt = wr_item;
        end else begin
          tail_nxt = wr_item;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = wr_item;
        end else begin
          head_nxt = tail_r;
          tail_nxt = wr_item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

### design/fdp_back.sv
// ----------------------------------------------------------------------------
// fdp_back
// Delta (encode) or accumulate and unmap (decode) against the history key, output register.
// ----------------------------------------------------------------------------
module fdp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fdp_pkg::mode_t mode,
  input  logic           q_valid,
  output logic           q_ready,
  input  fdp_pkg::item_t q_item,
  fdp_out_if.source      out_m
);
  import fdp_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] hist_r, hist_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              last_r, last_nxt;
  logic [WORD_W-1:0] diff, sum;
  logic              take;

  assign q_ready = !valid_r || out_m.ready;
  assign take    = q_valid && q_ready;

  assign diff = mode.byte_wise ? lanes_sub(q_item.word, hist_r) : (q_item.word - hist_r);
  assign sum  = mode.byte_wise ? lanes_add(hist_r, q_item.word) : (hist_r + q_item.word);

  always_comb begin
    valid_nxt = valid_r;
    hist_nxt  = hist_r;
    word_nxt  = word_r;
    last_nxt  = last_r;
    if (take) begin
      valid_nxt = 1'b1;
      last_nxt  = q_item.last;
      if (mode.direction) begin
        word_nxt = from_key(sum);
        hist_nxt = sum;
      end else begin
        word_nxt = diff;
        hist_nxt = q_item.word;
      end
      if (q_item.last) begin
        hist_nxt = '0;
      end
    end else if (out_m.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hist_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hist_r  <= hist_nxt;
    end
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_m.valid    = valid_r;
  assign out_m.out_word = word_r;
  assign out_m.last_out = last_r;

endmodule

### design/float_delta_prefilter.sv
// ----------------------------------------------------------------------------
// float_delta_prefilter
// Order-preserving float delta filter (encode) and its inverse (decode).
// ----------------------------------------------------------------------------
//  channel  dir  payload                  handshake
//  in_s     in   data_word[31:0], last_in valid/ready
//  out_m    out  out_word[31:0], last_out valid/ready
//  cfg_*    in   cfg_idx[1:0], cfg_data   cfg_we, no ready
//
//  One word per clock sustained while out_m is not stalled; an accepted word
//  passes the front register (loads on accept), the queue, then the output
//  register. The history add/subtract in the back stage is the only loop.
//  Synchronous active-low reset empties all stages, clears history and sets
//  both mode registers to 0. Either side may stall; the two-entry queue lets
//  front and back stall independently.
// ----------------------------------------------------------------------------
module float_delta_prefilter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fdp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fdp_pkg::CFG_DATA_W-1:0]    cfg_data,
  fdp_in_if.sink                            in_s,
  fdp_out_if.source                         out_m
);
  import fdp_pkg::*;

  logic  direction_r, byte_wise_r;
  mode_t mode;
  logic  f2q_valid, f2q_ready, q2b_valid, q2b_ready;
  item_t f2q_item, q2b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      byte_wise_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DIRECTION) begin
        direction_r <= cfg_data[0];
      end
      if (cfg_idx == CFG_BYTE_WISE) begin
        byte_wise_r <= cfg_data[0];
      end
    end
  end

  assign mode.direction = direction_r;
  assign mode.byte_wise = byte_wise_r;

  fdp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode),
    .in_s    (in_s),
    .q_valid (f2q_valid),
    .q_ready (f2q_ready),
    .q_item  (f2q_item)
  );

  fdp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f2q_valid),
    .wr_ready (f2q_ready),
    .wr_item  (f2q_item),
    .rd_valid (q2b_valid),
    .rd_ready (q2b_ready),
    .rd_item  (q2b_item)
  );

  fdp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode),
    .q_valid (q2b_valid),
    .q_ready (q2b_ready),
    .q_item  (q2b_item),
    .out_m   (out_m)
  );

  a_in_to_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> f2q_valid)
    else $error("accepted word did not reach front register");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f2q_valid && !f2q_ready |=> f2q_valid && $stable(f2q_item))
    else $error("front dropped or changed a word while queue full");

  a_back_load: assert property (@(posedge clk) disable iff (!rst_n)
    q2b_valid && q2b_ready |=> out_m.valid)
    else $error("word popped from queue but output register empty");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_m.valid && !f2q_valid && !q2b_valid)
    else $error("pipeline not empty after reset");

endmodule
